// ----- src/lprd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types, widths and codes of the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

   // Number parsing limits.
   localparam int MAX_DIGITS  = 12;
   localparam int LENGTH_BITS = 24;
   localparam int DIGIT_BITS  = $clog2(MAX_DIGITS + 1);

   // Field widths fixed by the stream format.
   localparam int BYTE_BITS    = 8;
   localparam int ARG_BITS     = 12;
   localparam int CFG_LEN_BITS = 24;
   localparam int CODE_BITS    = 3;
   localparam int CSR_IDX_BITS = 2;

   // Common width for comparing parsed values against the limit registers.
   localparam int WIDE_BITS =
      ((LENGTH_BITS > CFG_LEN_BITS) ? LENGTH_BITS : CFG_LEN_BITS) + 1;

   localparam int HDR_LEN  = 5;
   localparam int HDR_BITS = 3;

   localparam logic [BYTE_BITS-1:0] CHAR_LF   = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE = 8'h39;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ARGS          = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ARG_LEN       = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_REQUEST_BYTES = 2'd2;

   localparam logic [ARG_BITS-1:0]     MAX_ARGS_RESET          = 12'd256;
   localparam logic [CFG_LEN_BITS-1:0] MAX_ARG_LEN_RESET       = 24'd1048576;
   localparam logic [CFG_LEN_BITS-1:0] MAX_REQUEST_BYTES_RESET = 24'd4194304;

   // Error codes reported with each result.
   localparam logic [CODE_BITS-1:0] ERR_NONE       = 3'd0;
   localparam logic [CODE_BITS-1:0] ERR_HEADER     = 3'd1;
   localparam logic [CODE_BITS-1:0] ERR_LENGTH_TXT = 3'd2;
   localparam logic [CODE_BITS-1:0] ERR_OVER_CAP   = 3'd3;
   localparam logic [CODE_BITS-1:0] ERR_BUDGET     = 3'd4;
   localparam logic [CODE_BITS-1:0] ERR_NO_TERM    = 3'd5;

   typedef struct packed {
      logic                 action;
      logic [BYTE_BITS-1:0] byte_value;
   } item_type;

   typedef struct packed {
      logic [ARG_BITS-1:0]     max_args;
      logic [CFG_LEN_BITS-1:0] max_arg_len;
      logic [CFG_LEN_BITS-1:0] max_request_bytes;
   } cfg_type;

   typedef struct packed {
      logic                 payload_valid;
      logic [BYTE_BITS-1:0] payload_byte;
      logic [ARG_BITS-1:0]  arg_index;
      logic                 arg_done;
      logic                 request_done;
      logic [ARG_BITS-1:0]  arg_count;
      logic                 error_valid;
      logic [CODE_BITS-1:0] error_code;
   } result_type;

   // Characters of the "ARGS " header.
   function automatic logic [BYTE_BITS-1:0] hdr_char(input logic [HDR_BITS-1:0] pos);
      logic [BYTE_BITS-1:0] c;
      case (pos)
         3'd0:    c = 8'h41;
         3'd1:    c = 8'h52;
         3'd2:    c = 8'h47;
         3'd3:    c = 8'h53;
         3'd4:    c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- src/lprd_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_csr
// Limit registers of the deframer, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module lprd_csr
   import lprd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_LEN_BITS-1:0] csr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_ARGS:          cfg_in.max_args          = csr_data[ARG_BITS-1:0];
            CSR_MAX_ARG_LEN:       cfg_in.max_arg_len       = csr_data;
            CSR_MAX_REQUEST_BYTES: cfg_in.max_request_bytes = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_args          <= MAX_ARGS_RESET;
         cfg_ff.max_arg_len       <= MAX_ARG_LEN_RESET;
         cfg_ff.max_request_bytes <= MAX_REQUEST_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/lprd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_core
// Parse state machine: one byte per fire, result registered on the same edge.
// ----------------------------------------------------------------------------
module lprd_core
   import lprd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_COUNT,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_TERM,
      PH_IDLE
   } phase_type;

   localparam int NEXT_BITS = LENGTH_BITS + 4;

   phase_type               phase_ff,         phase_in;
   logic [HDR_BITS-1:0]     header_pos_ff,    header_pos_in;
   logic [DIGIT_BITS-1:0]   digit_count_ff,   digit_count_in;
   logic [LENGTH_BITS-1:0]  value_acc_ff,     value_acc_in;
   logic                    value_over_ff,    value_over_in;
   logic [ARG_BITS-1:0]     args_expected_ff, args_expected_in;
   logic [ARG_BITS-1:0]     current_arg_ff,   current_arg_in;
   logic [LENGTH_BITS-1:0]  bytes_left_ff,    bytes_left_in;
   logic [WIDE_BITS-1:0]    bytes_total_ff,   bytes_total_in;
   result_type              result_ff,        result_in;

   logic [BYTE_BITS-1:0]    b;
   logic                    is_digit;
   logic                    too_many;
   logic                    num_end;
   logic [NEXT_BITS-1:0]    acc_next;
   logic [WIDE_BITS-1:0]    acc_wide;
   logic [WIDE_BITS-1:0]    total_sum;
   logic [ARG_BITS-1:0]     arg_next;
   logic [LENGTH_BITS-1:0]  left_next;

   assign result = result_ff;

   always_comb begin
      b         = item.byte_value;
      is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      too_many  = (digit_count_ff >= DIGIT_BITS'(MAX_DIGITS));
      num_end   = (b == CHAR_LF) && (digit_count_ff != '0);
      // acc * 10 + digit, built from two shifts.
      acc_next  = {value_acc_ff, 3'b000} + {3'b000, value_acc_ff, 1'b0}
                + NEXT_BITS'(b[3:0]);
      acc_wide  = WIDE_BITS'(value_acc_ff);
      total_sum = bytes_total_ff + acc_wide;
      arg_next  = current_arg_ff + 1'b1;
      left_next = bytes_left_ff - 1'b1;
   end

   always_comb begin
      phase_in         = phase_ff;
      header_pos_in    = header_pos_ff;
      digit_count_in   = digit_count_ff;
      value_acc_in     = value_acc_ff;
      value_over_in    = value_over_ff;
      args_expected_in = args_expected_ff;
      current_arg_in   = current_arg_ff;
      bytes_left_in    = bytes_left_ff;
      bytes_total_in   = bytes_total_ff;
      result_in        = '0;

      if (item.action) begin
         phase_in         = PH_HEADER;
         header_pos_in    = '0;
         digit_count_in   = '0;
         value_acc_in     = '0;
         value_over_in    = 1'b0;
         args_expected_in = '0;
         current_arg_in   = '0;
         bytes_left_in    = '0;
         bytes_total_in   = '0;
      end else begin
         // Digit accumulation shared by the count and length lines.
         if ((phase_ff == PH_COUNT || phase_ff == PH_LENGTH) && is_digit && !too_many) begin
            digit_count_in = digit_count_ff + 1'b1;
            if (!value_over_ff) begin
               if (acc_next[NEXT_BITS-1:LENGTH_BITS] != '0) begin
                  value_over_in = 1'b1;
               end else begin
                  value_acc_in = acc_next[LENGTH_BITS-1:0];
               end
            end
         end

         unique case (phase_ff)
            PH_HEADER: begin
               if (header_pos_ff < HDR_BITS'(HDR_LEN) && b == hdr_char(header_pos_ff)) begin
                  header_pos_in = header_pos_ff + 1'b1;
                  if (header_pos_ff == HDR_BITS'(HDR_LEN - 1)) begin
                     phase_in       = PH_COUNT;
                     digit_count_in = '0;
                     value_acc_in   = '0;
                     value_over_in  = 1'b0;
                  end
               end else begin
                  result_in.error_code = ERR_HEADER;
               end
            end
            PH_COUNT: begin
               if (is_digit) begin
                  if (too_many) begin
                     result_in.error_code = ERR_LENGTH_TXT;
                  end
               end else if (!num_end) begin
                  result_in.error_code = ERR_LENGTH_TXT;
               end else if (value_over_ff || acc_wide > WIDE_BITS'(cfg.max_args)) begin
                  result_in.error_code = ERR_OVER_CAP;
               end else begin
                  args_expected_in = acc_wide[ARG_BITS-1:0];
                  current_arg_in   = '0;
                  bytes_total_in   = '0;
                  if (acc_wide[ARG_BITS-1:0] == '0) begin
                     result_in.request_done = 1'b1;
                     phase_in               = PH_IDLE;
                  end else begin
                     phase_in       = PH_LENGTH;
                     digit_count_in = '0;
                     value_acc_in   = '0;
                     value_over_in  = 1'b0;
                  end
               end
            end
            PH_LENGTH: begin
               result_in.arg_index = current_arg_ff;
               if (is_digit) begin
                  if (too_many) begin
                     result_in.error_code = ERR_LENGTH_TXT;
                  end
               end else if (!num_end) begin
                  result_in.error_code = ERR_LENGTH_TXT;
               end else if (value_over_ff || acc_wide > WIDE_BITS'(cfg.max_arg_len)) begin
                  result_in.error_code = ERR_OVER_CAP;
               end else begin
                  bytes_total_in = total_sum;
                  if (total_sum > WIDE_BITS'(cfg.max_request_bytes)) begin
                     result_in.error_code = ERR_BUDGET;
                  end else begin
                     bytes_left_in = value_acc_ff;
                     phase_in      = (value_acc_ff == '0) ? PH_TERM : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               result_in.payload_valid = 1'b1;
               result_in.payload_byte  = b;
               result_in.arg_index     = current_arg_ff;
               // A payload phase always starts with at least one byte to go.
               bytes_left_in = left_next;
               if (left_next == '0) begin
                  phase_in = PH_TERM;
               end
            end
            PH_TERM: begin
               result_in.arg_index = current_arg_ff;
               if (b == CHAR_LF) begin
                  result_in.arg_done = 1'b1;
                  current_arg_in     = arg_next;
                  if (arg_next >= args_expected_ff) begin
                     result_in.request_done = 1'b1;
                     phase_in               = PH_IDLE;
                  end else begin
                     phase_in       = PH_LENGTH;
                     digit_count_in = '0;
                     value_acc_in   = '0;
                     value_over_in  = 1'b0;
                  end
               end else begin
                  result_in.error_code = ERR_NO_TERM;
               end
            end
            PH_IDLE: begin
               result_in = '0;
            end
            default: begin
               result_in = '0;
            end
         endcase

         if (result_in.error_code != ERR_NONE) begin
            result_in.error_valid = 1'b1;
            phase_in              = PH_IDLE;
         end
      end

      result_in.arg_count = args_expected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_pos_ff    <= '0;
         digit_count_ff   <= '0;
         value_acc_ff     <= '0;
         value_over_ff    <= 1'b0;
         args_expected_ff <= '0;
         current_arg_ff   <= '0;
         bytes_left_ff    <= '0;
         bytes_total_ff   <= '0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         header_pos_ff    <= header_pos_in;
         digit_count_ff   <= digit_count_in;
         value_acc_ff     <= value_acc_in;
         value_over_ff    <= value_over_in;
         args_expected_ff <= args_expected_in;
         current_arg_ff   <= current_arg_in;
         bytes_left_ff    <= bytes_left_in;
         bytes_total_ff   <= bytes_total_in;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- src/length_prefixed_request_deframer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_unit
// Byte-stream deframer for "ARGS <n>" requests with length-prefixed arguments.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  tdata: byte_value; tuser: action
//   rsp_     out        rsp_tvalid/rsp_tready  one result per request byte
//   csr_     in         csr_valid/csr_ready    limit register writes
//
// Every accepted request transaction yields exactly one response transaction.
// The block takes one byte per clock while the response is not stalled: an
// accepted byte sits in the input register, and when the result register is
// free or being taken the parse state machine updates and loads the result
// register, which drives rsp_tvalid for the response transaction.
// The one-byte-per-clock figure is set by the single state update per byte.
// Reset is synchronous and active high; it restores the default limits and
// sends the parser to header matching. When the response is stalled the
// pipeline holds, and req_tready drops only once the input register is full.
//
// The parser expects "ARGS " followed by a decimal count and a newline, then
// for each argument a decimal length line, that many payload bytes and a bare
// newline. Any violation is reported on the byte that reveals it, after which
// the parser ignores stream bytes until a restart transaction (action set).
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_unit
   import lprd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,  // [7:0] byte_value
   input  logic [0:0]              req_tuser,  // [0] action

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata,  // [7:0] payload_byte, [19:8] arg_index,
                                               // [31:20] arg_count, [34:32] error_code,
                                               // [39:35] zero
   output logic [2:0]              rsp_tuser,  // [0] payload_valid, [1] arg_done,
                                               // [2] error_valid
   output logic                    rsp_tlast,  // request_done

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_LEN_BITS-1:0] csr_data
);

   cfg_type    cfg;
   result_type result;

   // Input register in front of the parser.
   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff;
   logic     out_valid_ff, out_valid_in;

   // The parse stage moves whenever the result register is free or being taken.
   logic advance;
   logic fire;
   logic req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_item_ff.action     <= req_tuser[0];
         in_item_ff.byte_value <= req_tdata;
      end
   end

   lprd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lprd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, result.error_code, result.arg_count,
                        result.arg_index, result.payload_byte};
   assign rsp_tuser  = {result.error_valid, result.arg_done, result.payload_valid};
   assign rsp_tlast  = result.request_done;

   // An error flag always comes with a nonzero code, and a clean result with none.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[2] == (rsp_tdata[34:32] != ERR_NONE)))
      else $error("error flag and error code disagree");

   // A response never reports completion or payload together with an error.
   a_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> !rsp_tlast && !rsp_tuser[0] && !rsp_tuser[1])
      else $error("error reported alongside payload or completion");

   // Payload bytes and argument terminators are distinct bytes.
   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && !rsp_tlast)
      else $error("payload byte flagged as terminator");

   // A full input register with a stalled result must hold off new requests.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request accepted while the pipeline is stalled and full");

   // A fire always produces a response on the next cycle.
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("parsed byte produced no response");

endmodule

// ----- dv/length_prefixed_request_deframer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_unit_tb
// Self-checking bench for the length-prefixed request deframer. A queue-fed
// driver streams request bytes and restarts into the block, a clocked monitor
// checks every response transaction against a behavioral deframer kept in
// step with the accepted input, and the limit registers are reprogrammed
// between phases.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_unit_tb;
   import lprd_pkg::*;

   // Parse phases of the behavioral deframer.
   typedef enum logic [2:0] {
      ST_HEADER,
      ST_COUNT,
      ST_LENGTH,
      ST_PAYLOAD,
      ST_TERM,
      ST_IDLE
   } parse_state_type;

   // Outcome of feeding one byte to a decimal number being parsed.
   typedef enum logic [1:0] {
      DIG_MORE,
      DIG_DONE,
      DIG_BAD
   } digit_status_type;

   // Shapes of generated request frames.
   typedef enum logic [3:0] {
      RQ_GOOD,
      RQ_CORRUPT,
      RQ_TRUNCATE,
      RQ_OVER_COUNT,
      RQ_OVER_LEN,
      RQ_OVER_BUDGET,
      RQ_NO_TERM,
      RQ_LONG_DIGITS,
      RQ_EMPTY_LEN,
      RQ_NOISE
   } req_kind_type;

   localparam int              NUM_PHASES      = 7;
   localparam int              ITEMS_PER_PHASE = 228;
   localparam int              WATCHDOG_LIMIT  = 1000;
   localparam int              DRAIN_CYCLES    = 4;
   localparam logic [39:0]     HEADER_TEXT     = "ARGS ";
   localparam longint unsigned LEN_LIMIT       = (longint'(1) << LENGTH_BITS) - 1;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;
   logic [0:0]              req_tuser  = '0;

   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [39:0]             rsp_tdata;
   logic [2:0]              rsp_tuser;
   logic                    rsp_tlast;

   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [CFG_LEN_BITS-1:0] csr_data   = '0;

   // Stimulus waiting for the driver and responses waiting for the monitor.
   item_type                pending_items[$];
   result_type              expected_results[$];
   logic [7:0]              frame_bytes[$];

   // Limit registers as the bench believes them to be programmed.
   logic [ARG_BITS-1:0]     lim_max_args          = MAX_ARGS_RESET;
   logic [CFG_LEN_BITS-1:0] lim_max_arg_len       = MAX_ARG_LEN_RESET;
   logic [CFG_LEN_BITS-1:0] lim_max_request_bytes = MAX_REQUEST_BYTES_RESET;

   // Behavioral deframer state.
   parse_state_type         parse_state;
   int                      hdr_pos;
   int                      digits_seen;
   longint unsigned         num_value;
   logic                    num_over;
   logic [ARG_BITS-1:0]     args_expected;
   logic [ARG_BITS-1:0]     arg_cursor;
   longint unsigned         bytes_left;
   longint unsigned         bytes_total;

   int                      mismatch_count = 0;
   int                      items_accepted = 0;
   int                      results_checked = 0;
   int                      requests_done = 0;
   int                      errors_flagged = 0;
   int                      settings_used = 1;
   int                      hold_off = 0;
   int                      stall_left = 0;
   int                      quiet_cycles = 0;
   logic                    drive_calm = 1'b0;
   logic                    sink_calm = 1'b0;

   length_prefixed_request_deframer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Behavioral deframer
   // ------------------------------------------------------------------------

   function automatic logic [7:0] header_char(input int pos);
      return HEADER_TEXT[8*(HDR_LEN-1-pos) +: 8];
   endfunction

   function automatic void start_number();
      digits_seen = 0;
      num_value   = 0;
      num_over    = 1'b0;
   endfunction

   function automatic void clear_parse();
      parse_state   = ST_HEADER;
      hdr_pos       = 0;
      args_expected = '0;
      arg_cursor    = '0;
      bytes_left    = 0;
      bytes_total   = 0;
      start_number();
   endfunction

   // Digits accumulate until a newline closes the number. A value past the
   // length range is only remembered as overflowed, so it fails any cap later.
   function automatic digit_status_type take_digit(input logic [7:0] b);
      longint unsigned nxt;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         if (digits_seen >= MAX_DIGITS) return DIG_BAD;
         digits_seen++;
         if (!num_over) begin
            nxt = num_value * 10 + longint'(b - CHAR_ZERO);
            if (nxt > LEN_LIMIT) num_over = 1'b1;
            else num_value = nxt;
         end
         return DIG_MORE;
      end
      if (b == CHAR_LF && digits_seen > 0) return DIG_DONE;
      return DIG_BAD;
   endfunction

   // Advances the deframer by one accepted transaction and returns the
   // response that the block owes for it.
   function automatic result_type deframe_byte(input logic restart, input logic [7:0] b);
      result_type           res;
      logic [CODE_BITS-1:0] err;
      digit_status_type     st;
      res = '0;
      err = ERR_NONE;
      if (restart) begin
         clear_parse();
      end else begin
         case (parse_state)
            ST_HEADER: begin
               if (hdr_pos < HDR_LEN && b == header_char(hdr_pos)) begin
                  hdr_pos++;
                  if (hdr_pos == HDR_LEN) begin
                     parse_state = ST_COUNT;
                     start_number();
                  end
               end else begin
                  err = ERR_HEADER;
               end
            end
            ST_COUNT: begin
               st = take_digit(b);
               if (st == DIG_BAD) begin
                  err = ERR_LENGTH_TXT;
               end else if (st == DIG_DONE) begin
                  if (num_over || num_value > lim_max_args) begin
                     err = ERR_OVER_CAP;
                  end else begin
                     args_expected = num_value[ARG_BITS-1:0];
                     arg_cursor    = '0;
                     bytes_total   = 0;
                     // A count of zero is already a complete request.
                     if (args_expected == 0) begin
                        res.request_done = 1'b1;
                        parse_state      = ST_IDLE;
                     end else begin
                        parse_state = ST_LENGTH;
                        start_number();
                     end
                  end
               end
            end
            ST_LENGTH: begin
               res.arg_index = arg_cursor;
               st = take_digit(b);
               if (st == DIG_BAD) begin
                  err = ERR_LENGTH_TXT;
               end else if (st == DIG_DONE) begin
                  if (num_over || num_value > lim_max_arg_len) begin
                     err = ERR_OVER_CAP;
                  end else begin
                     bytes_total += num_value;
                     if (bytes_total > lim_max_request_bytes) begin
                        err = ERR_BUDGET;
                     end else begin
                        bytes_left  = num_value;
                        parse_state = (bytes_left == 0) ? ST_TERM : ST_PAYLOAD;
                     end
                  end
               end
            end
            ST_PAYLOAD: begin
               res.payload_valid = 1'b1;
               res.payload_byte  = b;
               res.arg_index     = arg_cursor;
               if (bytes_left > 0) bytes_left--;
               if (bytes_left == 0) parse_state = ST_TERM;
            end
            ST_TERM: begin
               res.arg_index = arg_cursor;
               if (b == CHAR_LF) begin
                  res.arg_done = 1'b1;
                  arg_cursor++;
                  if (arg_cursor >= args_expected) begin
                     res.request_done = 1'b1;
                     parse_state      = ST_IDLE;
                  end else begin
                     parse_state = ST_LENGTH;
                     start_number();
                  end
               end else begin
                  err = ERR_NO_TERM;
               end
            end
            default: begin
            end
         endcase
         if (err != ERR_NONE) parse_state = ST_IDLE;
      end
      res.arg_count   = args_expected;
      res.error_valid = (err != ERR_NONE);
      res.error_code  = err;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   function automatic void queue_item(input logic restart, input logic [7:0] b);
      item_type it;
      it.action     = restart;
      it.byte_value = b;
      pending_items = {pending_items, it};
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_item(1'b0, s[i]);
   endfunction

   function automatic int unsigned smaller(input int unsigned a, input int unsigned b);
      return (a < b) ? a : b;
   endfunction

   // Appends one byte to the frame under construction.
   function automatic void add_byte(input logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endfunction

   // Decimal text of value, padded with leading zeros up to width digits.
   function automatic void add_number(input longint unsigned value, input int width);
      logic [7:0] digs[$];
      do begin
         digs.push_front(CHAR_ZERO + 8'(value % 10));
         value = value / 10;
      end while (value > 0);
      while (digs.size() < width) digs.push_front(CHAR_ZERO);
      foreach (digs[i]) add_byte(digs[i]);
   endfunction

   // Now and then a number is written with the full twelve digits.
   function automatic int pick_width();
      return ($urandom_range(0, 9) == 0) ? MAX_DIGITS : 0;
   endfunction

   // Builds a request into frame_bytes under the current limits. Error kinds stop
   // the frame after the flagged byte, but a too-long digit run keeps its newline.
   function automatic void build_request(input req_kind_type kind);
      int unsigned n_args;
      int unsigned len;
      int unsigned total;
      logic        is_last;
      for (int i = 0; i < HDR_LEN; i++) add_byte(header_char(i));
      if (kind == RQ_OVER_COUNT) begin
         add_number(longint'(lim_max_args) + 1 + longint'($urandom_range(0, 3)),
                    pick_width());
         add_byte(CHAR_LF);
         return;
      end
      n_args = $urandom_range(0, smaller(int'(lim_max_args), 4));
      if (kind != RQ_GOOD && n_args == 0 && lim_max_args > 0) n_args = 1;
      add_number(longint'(n_args), pick_width());
      add_byte(CHAR_LF);
      total = 0;
      for (int unsigned i = 0; i < n_args; i++) begin
         is_last = (i == n_args - 1);
         if (is_last && kind == RQ_OVER_LEN) begin
            add_number(longint'(lim_max_arg_len) + 1 + longint'($urandom_range(0, 9)), 0);
            add_byte(CHAR_LF);
            return;
         end
         if (is_last && kind == RQ_OVER_BUDGET) begin
            add_number(longint'(lim_max_request_bytes) - longint'(total) + 1, 0);
            add_byte(CHAR_LF);
            return;
         end
         if (i == 0 && kind == RQ_LONG_DIGITS) begin
            add_number(longint'($urandom_range(0, 9)), MAX_DIGITS + 1);
            add_byte(CHAR_LF);
            return;
         end
         if (i == 0 && kind == RQ_EMPTY_LEN) begin
            add_byte(CHAR_LF);
            return;
         end
         len = $urandom_range(0, smaller(smaller(int'(lim_max_arg_len), 6),
                                         int'(lim_max_request_bytes) - total));
         add_number(longint'(len), pick_width());
         add_byte(CHAR_LF);
         repeat (len) add_byte(8'($urandom_range(0, 255)));
         total += len;
         if (is_last && kind == RQ_NO_TERM) begin
            add_byte(8'($urandom_range(CHAR_LF + 1, 255)));
            return;
         end
         add_byte(CHAR_LF);
      end
   endfunction

   function automatic req_kind_type choose_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return RQ_GOOD;
      if (r < 57) return RQ_CORRUPT;
      if (r < 64) return RQ_TRUNCATE;
      if (r < 70) return RQ_OVER_COUNT;
      if (r < 76) return RQ_OVER_LEN;
      if (r < 82) return RQ_OVER_BUDGET;
      if (r < 88) return RQ_NO_TERM;
      if (r < 92) return RQ_LONG_DIGITS;
      if (r < 95) return RQ_EMPTY_LEN;
      return RQ_NOISE;
   endfunction

   // Queues one frame, up to two bytes the idle parser should ignore, and the
   // restart that opens the next request. Returns the number of items queued.
   function automatic int emit_request(input req_kind_type kind);
      int unsigned pos;
      int unsigned idle_n;
      frame_bytes.delete();
      if (kind == RQ_NOISE) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         build_request((kind == RQ_CORRUPT || kind == RQ_TRUNCATE) ? RQ_GOOD : kind);
         pos = $urandom_range(0, frame_bytes.size() - 1);
         if (kind == RQ_CORRUPT) begin
            frame_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
         end else if (kind == RQ_TRUNCATE) begin
            while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
         end
      end
      foreach (frame_bytes[i]) queue_item(1'b0, frame_bytes[i]);
      idle_n = $urandom_range(0, 2);
      repeat (idle_n) queue_item(1'b0, 8'($urandom_range(0, 255)));
      queue_item(1'b1, 8'($urandom_range(0, 255)));
      return int'(frame_bytes.size() + idle_n + 1);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration writes and phase control
   // ------------------------------------------------------------------------

   task automatic write_limit(input logic [CSR_IDX_BITS-1:0] idx,
                              input logic [CFG_LEN_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_ARGS:          lim_max_args          = value[ARG_BITS-1:0];
         CSR_MAX_ARG_LEN:       lim_max_arg_len       = value;
         CSR_MAX_REQUEST_BYTES: lim_max_request_bytes = value;
         default: begin
         end
      endcase
   endtask

   task automatic program_limits(input logic [CFG_LEN_BITS-1:0] args_cap,
                                 input logic [CFG_LEN_BITS-1:0] len_cap,
                                 input logic [CFG_LEN_BITS-1:0] budget);
      write_limit(CSR_MAX_ARGS, args_cap);
      write_limit(CSR_MAX_ARG_LEN, len_cap);
      write_limit(CSR_MAX_REQUEST_BYTES, budget);
      settings_used++;
   endtask

   // Every transaction yields a response, so once the queues are empty the
   // block is idle; the drain wait that follows is only a safety margin.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: presents queued items, predicting each response at the
   // edge where its transaction is accepted. A random hold-off precedes each
   // item, except during calm stretches.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic       load;
      item_type   nxt;
      result_type pred;
      load = 1'b0;
      nxt  = '0;
      if (reset) begin
         req_tvalid <= 1'b0;
         hold_off = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pred = deframe_byte(req_tuser[0], req_tdata);
            expected_results = {expected_results, pred};
            items_accepted++;
            hold_off = drive_calm ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) drive_calm = !drive_calm;
         end
         if (!req_tvalid || req_tready) begin
            if (hold_off > 0) begin
               hold_off--;
            end else if (pending_items.size() > 0) begin
               nxt  = pending_items.pop_front();
               load = 1'b1;
            end
         end
         // At most one update of req_tvalid per edge.
         if (load) begin
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.byte_value;
            req_tuser  <= nxt.action;
         end else if (!req_tvalid || req_tready) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: checks each accepted response against the oldest
   // prediction and applies random back-pressure, except in calm stretches.
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch_rsp
      result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response transaction arrived with no prediction pending");
               mismatch_count++;
            end else begin
               exp_r = expected_results.pop_front();
               results_checked++;
               if (exp_r.request_done) requests_done++;
               if (exp_r.error_valid) errors_flagged++;
               check_field("payload_valid", exp_r.payload_valid, rsp_tuser[0]);
               check_field("payload_byte", exp_r.payload_byte, rsp_tdata[7:0]);
               check_field("arg_index", exp_r.arg_index, rsp_tdata[19:8]);
               check_field("arg_done", exp_r.arg_done, rsp_tuser[1]);
               check_field("request_done", exp_r.request_done, rsp_tlast);
               check_field("arg_count", exp_r.arg_count, rsp_tdata[31:20]);
               check_field("error_valid", exp_r.error_valid, rsp_tuser[2]);
               check_field("error_code", exp_r.error_code, rsp_tdata[34:32]);
               check_field("tdata padding", 0, rsp_tdata[39:35]);
            end
            stall_left = sink_calm ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: a long run of cycles with no transaction on any channel means
   // the block has hung, so the run ends as a failure.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence: reset, a short directed part under the default limits,
   // then phases of random requests, each under its own limit setting.
   // ------------------------------------------------------------------------
   initial begin
      int produced;
      clear_parse();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: restart with all data bits set, a zero count, a byte
      // ignored while idle, a zero-length argument, and a header broken by a
      // newline.
      queue_item(1'b1, 8'hFF);
      queue_text("ARGS 0\n");
      queue_item(1'b0, 8'hFF);
      queue_item(1'b1, 8'h00);
      queue_text("ARGS 1\n0\n\n");
      queue_item(1'b1, 8'h00);
      queue_text("AR\n");
      queue_item(1'b1, 8'h00);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         // Phase 0 runs on the reset values; the others cover tight caps,
         // both extremes, a random setting, and the defaults written back.
         case (ph)
            1: program_limits(3, 5, 12);
            2: program_limits(0, 0, 0);
            3: program_limits(24'hFFF, 24'hFFFFFF, 24'hFFFFFF);
            4: program_limits(6, 8, 20);
            5: program_limits(CFG_LEN_BITS'($urandom_range(1, 8)),
                              CFG_LEN_BITS'($urandom_range(0, 10)),
                              CFG_LEN_BITS'($urandom_range(0, 30)));
            6: program_limits(CFG_LEN_BITS'(MAX_ARGS_RESET), MAX_ARG_LEN_RESET,
                              MAX_REQUEST_BYTES_RESET);
            default: begin
            end
         endcase
         produced = 0;
         while (produced < ITEMS_PER_PHASE) produced += emit_request(choose_kind());
      end

      wait_idle();
      if (expected_results.size() != 0) begin
         $error("%0d predicted responses never arrived", expected_results.size());
         mismatch_count++;
      end

      $display("Streamed %0d transactions under %0d limit settings and checked %0d responses.",
               items_accepted, settings_used, results_checked);
      $display("Requests completed: %0d, format errors flagged: %0d, mismatches: %0d.",
               requests_done, errors_flagged, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
